### rtl/core/rptg_pkg.sv
// shared types and constants of the ramped pulse train generator
package rptg_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned TIMER_W     = 16;
   localparam int unsigned ON_TIME_W   = 17;
   localparam int unsigned STEP_W      = 10;
   localparam int unsigned COUNT_W     = 6;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_ON_TIME    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ON_TIME_STEP    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFF_TIME        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PULSE_COUNT     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_GAP       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SYNC_WIDTH      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNT_REDUCTION = 3'd6;

   // register reset values
   localparam logic [TIMER_W-1:0] RST_BASE_ON_TIME    = 16'd1000;
   localparam logic [STEP_W-1:0]  RST_ON_TIME_STEP    = 10'd50;
   localparam logic [TIMER_W-1:0] RST_OFF_TIME        = 16'd1200;
   localparam logic [COUNT_W-1:0] RST_PULSE_COUNT     = 6'd11;
   localparam logic [TIMER_W-1:0] RST_FRAME_GAP       = 16'd6500;
   localparam logic [STEP_W-1:0]  RST_SYNC_WIDTH      = 10'd50;
   localparam logic [COUNT_W-1:0] RST_COUNT_REDUCTION = 6'd3;

   typedef struct packed {
      logic [TIMER_W-1:0] base_on_time;
      logic [STEP_W-1:0]  on_time_step;
      logic [TIMER_W-1:0] off_time;
      logic [COUNT_W-1:0] pulse_count;
      logic [TIMER_W-1:0] frame_gap;
      logic [STEP_W-1:0]  sync_width;
      logic [COUNT_W-1:0] count_reduction;
   } cfg_type;

endpackage

### rtl/core/ramped_pulse_train_generator.sv
// ramped pulse train generator: one tick per beat, frame sequencer and output register
//
//   channel  direction  ports                          content
//   req      in         req_tvalid/tready/tdata[7:0]   one tick: button levels
//   rsp      out        rsp_tvalid/tready/tdata[7:0]   one tick: sync and data levels
//   csr      in         csr_valid/ready/index/data     register write, always ready
//
// one req beat is taken per cycle; its rsp beat appears the next cycle from
// the output register. the phase update of a tick, including zero-length
// phase skips, is combinational. req_tready drops only while a finished
// rsp beat is held by rsp_tready low. reset loads the register defaults,
// sets the enable flag and leaves the sequencer idle between frames.
module ramped_pulse_train_generator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] enable_button, [1] select_button
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] sync_level, [1] data_level
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [rptg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rptg_pkg::CSR_DATA_W-1:0]  csr_data
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SYNC,
      PH_HIGH,
      PH_LOW,
      PH_GAP
   } phase_type;

   typedef struct packed {
      phase_type                          phase;
      logic [rptg_pkg::TIMER_W-1:0]       timer;
      logic [rptg_pkg::COUNT_W-1:0]       idx;
      logic [rptg_pkg::ON_TIME_W-1:0]     on_time;
      logic                               enable_flag;
      logic                               alt_flag;
      logic [1:0]                         prev_buttons;
   } seq_type;

   rptg_pkg::cfg_type cfg_ff;
   seq_type           seq_ff, seq_in, seq_start;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [1:0]        rsp_level_ff, rsp_level_in;
   logic [1:0]        buttons;
   logic [1:0]        rise;
   logic              accept;

   function automatic logic [rptg_pkg::COUNT_W-1:0] frame_pulses(
      input rptg_pkg::cfg_type c, input logic alt);
      logic [rptg_pkg::COUNT_W-1:0] cut;
      cut = alt ? c.count_reduction : '0;
      return (c.pulse_count > cut) ? c.pulse_count - cut : '0;
   endfunction

   function automatic seq_type enter_gap(input rptg_pkg::cfg_type c, input seq_type s);
      seq_type r;
      r = s;
      r.timer = c.frame_gap;
      r.phase = (c.frame_gap != '0) ? PH_GAP : PH_IDLE;
      return r;
   endfunction

   // start a data pulse with a known high time; empty pulses fall through
   function automatic seq_type enter_high(input rptg_pkg::cfg_type c, input seq_type s,
      input logic [rptg_pkg::COUNT_W-1:0] idx, input logic [rptg_pkg::ON_TIME_W-1:0] cot,
      input logic [rptg_pkg::COUNT_W-1:0] n);
      seq_type r;
      r = s;
      r.idx = idx;
      r.on_time = cot;
      if (cot != '0) begin
         r.phase = PH_HIGH;
      end else if (c.off_time != '0) begin
         r.phase = PH_LOW;
         r.timer = c.off_time;
      end else if (c.on_time_step != '0 && n > rptg_pkg::COUNT_W'(1)) begin
         // only the first pulse can be empty with a nonzero step
         r.idx = rptg_pkg::COUNT_W'(1);
         r.on_time = rptg_pkg::ON_TIME_W'(c.on_time_step);
         r.phase = PH_HIGH;
      end else begin
         r = enter_gap(c, r);
      end
      return r;
   endfunction

   function automatic seq_type enter_next(input rptg_pkg::cfg_type c, input seq_type s,
      input logic [rptg_pkg::COUNT_W-1:0] n);
      logic [rptg_pkg::COUNT_W-1:0]   idx;
      logic [rptg_pkg::ON_TIME_W-1:0] cot;
      seq_type r;
      idx = s.idx + rptg_pkg::COUNT_W'(1);
      cot = {1'b0, c.base_on_time}
          + {1'b0, rptg_pkg::TIMER_W'(idx) * rptg_pkg::TIMER_W'(c.on_time_step)};
      if (idx < n && idx != '0) begin
         r = enter_high(c, s, idx, cot, n);
      end else begin
         r = enter_gap(c, s);
         r.idx = idx;
      end
      return r;
   endfunction

   function automatic seq_type enter_low(input rptg_pkg::cfg_type c, input seq_type s,
      input logic [rptg_pkg::COUNT_W-1:0] n);
      seq_type r;
      r = s;
      if (c.off_time != '0) begin
         r.phase = PH_LOW;
         r.timer = c.off_time;
      end else begin
         r = enter_next(c, s, n);
      end
      return r;
   endfunction

   function automatic seq_type enter_start(input rptg_pkg::cfg_type c, input seq_type s,
      input logic [rptg_pkg::COUNT_W-1:0] n);
      seq_type r;
      if (n != '0) begin
         r = enter_high(c, s, '0, {1'b0, c.base_on_time}, n);
      end else begin
         r = enter_gap(c, s);
         r.idx = '0;
      end
      return r;
   endfunction

   assign buttons    = req_tdata[1:0];
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {6'd0, rsp_level_ff};
   assign rise       = buttons & ~seq_ff.prev_buttons;

   // idle tick: sample buttons, maybe open a frame
   always_comb begin
      seq_start = seq_ff;
      if (seq_ff.phase == PH_IDLE) begin
         seq_start.enable_flag  = seq_ff.enable_flag ^ rise[0];
         seq_start.alt_flag     = seq_ff.alt_flag ^ rise[1];
         seq_start.prev_buttons = buttons;
         if (seq_start.enable_flag && buttons == 2'b00) begin
            if (cfg_ff.sync_width != '0) begin
               seq_start.phase = PH_SYNC;
               seq_start.timer = rptg_pkg::TIMER_W'(cfg_ff.sync_width);
            end else begin
               seq_start = enter_start(cfg_ff, seq_start,
                                       frame_pulses(cfg_ff, seq_start.alt_flag));
            end
         end
      end
   end

   // level output of this tick, then count down the current phase
   always_comb begin
      logic [rptg_pkg::COUNT_W-1:0]   n;
      logic [rptg_pkg::TIMER_W-1:0]   t_dec;
      logic [rptg_pkg::ON_TIME_W-1:0] cot_dec;
      n       = frame_pulses(cfg_ff, seq_start.alt_flag);
      t_dec   = seq_start.timer - rptg_pkg::TIMER_W'(1);
      cot_dec = seq_start.on_time - rptg_pkg::ON_TIME_W'(1);
      rsp_level_in = {seq_start.phase == PH_HIGH, seq_start.phase == PH_SYNC};
      seq_in = seq_start;
      case (seq_start.phase)
         PH_SYNC: begin
            seq_in.timer = t_dec;
            if (t_dec == '0) seq_in = enter_start(cfg_ff, seq_in, n);
         end
         PH_HIGH: begin
            seq_in.on_time = cot_dec;
            if (cot_dec == '0) seq_in = enter_low(cfg_ff, seq_in, n);
         end
         PH_LOW: begin
            seq_in.timer = t_dec;
            if (t_dec == '0) seq_in = enter_next(cfg_ff, seq_in, n);
         end
         PH_GAP: begin
            seq_in.timer = t_dec;
            if (t_dec == '0) seq_in.phase = PH_IDLE;
         end
         default: ;
      endcase
      rsp_tvalid_in = accept || (rsp_tvalid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_on_time    <= rptg_pkg::RST_BASE_ON_TIME;
         cfg_ff.on_time_step    <= rptg_pkg::RST_ON_TIME_STEP;
         cfg_ff.off_time        <= rptg_pkg::RST_OFF_TIME;
         cfg_ff.pulse_count     <= rptg_pkg::RST_PULSE_COUNT;
         cfg_ff.frame_gap       <= rptg_pkg::RST_FRAME_GAP;
         cfg_ff.sync_width      <= rptg_pkg::RST_SYNC_WIDTH;
         cfg_ff.count_reduction <= rptg_pkg::RST_COUNT_REDUCTION;
      end else if (csr_valid) begin
         case (csr_index)
            rptg_pkg::CSR_BASE_ON_TIME:    cfg_ff.base_on_time    <= csr_data;
            rptg_pkg::CSR_ON_TIME_STEP:    cfg_ff.on_time_step    <= csr_data[9:0];
            rptg_pkg::CSR_OFF_TIME:        cfg_ff.off_time        <= csr_data;
            rptg_pkg::CSR_PULSE_COUNT:     cfg_ff.pulse_count     <= csr_data[5:0];
            rptg_pkg::CSR_FRAME_GAP:       cfg_ff.frame_gap       <= csr_data;
            rptg_pkg::CSR_SYNC_WIDTH:      cfg_ff.sync_width      <= csr_data[9:0];
            rptg_pkg::CSR_COUNT_REDUCTION: cfg_ff.count_reduction <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff.phase        <= PH_IDLE;
         seq_ff.timer        <= '0;
         seq_ff.idx          <= '0;
         seq_ff.on_time      <= '0;
         seq_ff.enable_flag  <= 1'b1;
         seq_ff.alt_flag     <= 1'b0;
         seq_ff.prev_buttons <= 2'b00;
         rsp_tvalid_ff       <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (accept) seq_ff <= seq_in;
      end
   end

   // payload of the result beat
   always_ff @(posedge clock) begin
      if (accept) rsp_level_ff <= rsp_level_in;
   end

endmodule
